/* hdl/serial_command_frame_parser_core_assert.svh */
// Assertion macros shared by the frame parser RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SCFP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication.
`define SCFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

/* hdl/scfp_pkg.sv */
// Package for the serial command frame parser: phase and event codes,
// parser state and result types, protocol constants. No dependencies.
`default_nettype none

package scfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAXLEN_W = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;

  localparam logic                RST_SERVER_MODE = 1'b1;
  localparam logic [MAXLEN_W-1:0] RST_MAX_LEN     = 8'd64;

  localparam logic [CFG_IDX_W-1:0] REG_SERVER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 1'd1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_M    = 3'd1,
    PH_DIR  = 3'd2,
    PH_LEN  = 3'd3,
    PH_CMD  = 3'd4,
    PH_DATA = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BADSUM  = 3'd4,
    EV_TOOLONG = 3'd5
  } ev_code_t;

  typedef struct packed {
    phase_t            phase;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] frame_command;
    logic [BYTE_W-1:0] byte_offset;
    logic [BYTE_W-1:0] checksum;
  } parse_state_t;

  typedef struct packed {
    ev_code_t          ev_code;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] payload_length;
  } parse_result_t;

endpackage

`default_nettype wire

/* hdl/scfp_step.sv */
// Next-state and result logic of the frame parser for one received byte.
// Depends on scfp_pkg.
`default_nettype none

module scfp_step
  import scfp_pkg::*;
(
  input  parse_state_t        state_cur,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic                server_mode,
  input  logic [MAXLEN_W-1:0] max_len,
  output parse_state_t        state_nxt,
  output parse_result_t       result
);

  logic [BYTE_W-1:0] dir_want;

  assign dir_want = server_mode ? CH_LT : CH_GT;

  always_comb begin
    state_nxt             = state_cur;
    result.ev_code        = EV_IGNORED;
    result.payload_byte   = '0;
    result.payload_index  = '0;
    result.command_code   = '0;
    result.payload_length = '0;

    case (state_cur.phase)
      PH_M: begin
        if (rx_byte == CH_M) begin
          state_nxt.phase = PH_DIR;
          result.ev_code  = EV_HEADER;
        end else begin
          state_nxt.phase = PH_IDLE;
        end
      end
      PH_DIR: begin
        if (rx_byte == dir_want) begin
          state_nxt.phase = PH_LEN;
          result.ev_code  = EV_HEADER;
        end
      end
      PH_LEN: begin
        if (rx_byte > max_len) begin
          state_nxt.phase       = PH_IDLE;
          result.ev_code        = EV_TOOLONG;
          result.payload_length = rx_byte;
        end else begin
          state_nxt.frame_length = rx_byte;
          state_nxt.byte_offset  = '0;
          state_nxt.checksum     = rx_byte;
          state_nxt.phase        = PH_CMD;
          result.ev_code         = EV_HEADER;
        end
      end
      PH_CMD: begin
        state_nxt.frame_command = rx_byte;
        state_nxt.checksum      = state_cur.checksum ^ rx_byte;
        state_nxt.phase         = PH_DATA;
        result.ev_code          = EV_HEADER;
      end
      PH_DATA: begin
        result.command_code   = state_cur.frame_command;
        result.payload_length = state_cur.frame_length;
        if (state_cur.byte_offset < state_cur.frame_length) begin
          result.ev_code        = EV_PAYLOAD;
          result.payload_byte   = rx_byte;
          result.payload_index  = state_cur.byte_offset;
          state_nxt.checksum    = state_cur.checksum ^ rx_byte;
          state_nxt.byte_offset = state_cur.byte_offset + 8'd1;
        end else begin
          result.ev_code  = (rx_byte == state_cur.checksum) ? EV_GOOD : EV_BADSUM;
          state_nxt.phase = PH_IDLE;
        end
      end
      default: begin
        if (rx_byte == CH_DOLLAR) begin
          state_nxt.phase = PH_M;
          result.ev_code  = EV_HEADER;
        end else if (rx_byte == CH_M) begin
          state_nxt.phase = PH_DIR;
          result.ev_code  = EV_HEADER;
        end else begin
          state_nxt.phase = PH_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/serial_command_frame_parser_core.sv */
// Serial command frame parser, top level. Uses scfp_pkg, scfp_step and the assert macros.
// A byte accepted on the input passes the input register, then the result register, before
// its result shows on out_valid; out_stall can hold it in the input register.
// Throughput: one byte per cycle while out_stall does not hold the output; the parser state updates in the same cycle.
// Reset (synchronous, rst_n low): parser idle, config back to server mode and
// max length 64, both stages empty.
`default_nettype none

module serial_command_frame_parser_core
  import scfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_rx_byte,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_res,
  output logic [BYTE_W-1:0]     out_payload_byte,
  output logic [BYTE_W-1:0]     out_payload_index,
  output logic [BYTE_W-1:0]     out_command_code,
  output logic [BYTE_W-1:0]     out_payload_length
);

`include "serial_command_frame_parser_core_assert.svh"

  logic                server_mode_r;
  logic [MAXLEN_W-1:0] max_len_r;

  logic                in_vld_r;
  logic [BYTE_W-1:0]   in_byte_r;

  parse_state_t        state_r;
  parse_state_t        state_nxt;
  parse_result_t       result_nxt;

  logic                out_vld_r;
  parse_result_t       out_res_r;

  logic                adv;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_mode_r <= RST_SERVER_MODE;
      max_len_r     <= RST_MAX_LEN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SERVER_MODE: server_mode_r <= cfg_data[0];
        REG_MAX_LEN:     max_len_r     <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  scfp_step u_step (
    .state_cur   (state_r),
    .rx_byte     (in_byte_r),
    .server_mode (server_mode_r),
    .max_len     (max_len_r),
    .state_nxt   (state_nxt),
    .result      (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_IDLE;
      state_r.frame_length  <= '0;
      state_r.frame_command <= '0;
      state_r.byte_offset   <= '0;
      state_r.checksum      <= '0;
      out_vld_r             <= 1'b0;
    end else if (adv) begin
      state_r   <= state_nxt;
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= result_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_event_res      = 3'(out_res_r.ev_code);
  assign out_payload_byte   = out_res_r.payload_byte;
  assign out_payload_index  = out_res_r.payload_index;
  assign out_command_code   = out_res_r.command_code;
  assign out_payload_length = out_res_r.payload_length;

  `SCFP_ASSERT_IMPLY(a_data_offset_in_range, state_r.phase == PH_DATA,
                     state_r.byte_offset <= state_r.frame_length)
  `SCFP_ASSERT_IMPLY(a_payload_zero_off_event,
                     out_vld_r && out_res_r.ev_code != EV_PAYLOAD,
                     out_res_r.payload_byte == '0 && out_res_r.payload_index == '0)
  `SCFP_ASSERT_NEXT(a_adv_gives_result, adv, out_vld_r)

endmodule

`default_nettype wire
